// ===== src/rrts_pkg.sv =====
// Shared types and constants of the round-robin task scheduler.
// No dependencies; every other source file depends on this package.
package rrts_pkg;

    // Fixed field widths
    localparam int CMD_W     = 2;
    localparam int TASK_W    = 5;
    localparam int STAT_W    = 2;
    localparam int BASE_W    = 13;
    localparam int SEL_W     = 16;
    localparam int SEL_SHIFT = 3;   // selector = (base + task) * 8

    localparam logic [BASE_W-1:0] BASE_RESET = 13'd3;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_SLEEP = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_NO_SLOT = 2'd1,
        STAT_IGNORED = 2'd2
    } t_status;

    // Task slot states
    typedef enum logic [1:0] {
        SLOT_UNUSED  = 2'd0,
        SLOT_SLEEP   = 2'd1,
        SLOT_RUNNING = 2'd2
    } t_slot;

    // Read/write strobes of a memory port
    typedef struct packed {
        logic re;
        logic we;
    } t_mem_ctl;

endpackage

// ===== src/rrts_cmd_if.sv =====
// Command channel of the task scheduler: valid/ready plus one command word.
// Depends on rrts_pkg for field widths.
interface rrts_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [rrts_pkg::CMD_W-1:0]       command;
    logic [rrts_pkg::TASK_W-1:0]      task_index;

    modport source (output valid, output command, output task_index, input ready);
    modport sink   (input valid, input command, input task_index, output ready);
endinterface

// ===== src/rrts_res_if.sv =====
// Result channel of the task scheduler: valid/ready plus one result word.
// Depends on rrts_pkg for field widths.
interface rrts_res_if;
    logic                             valid;
    logic                             ready;
    logic [rrts_pkg::STAT_W-1:0]      status;
    logic                             switched;
    logic [rrts_pkg::TASK_W-1:0]      chosen_task;
    logic [rrts_pkg::SEL_W-1:0]       segment_selector;

    modport source (output valid, output status, output switched, output chosen_task,
                    output segment_selector, input ready);
    modport sink   (input valid, input status, input switched, input chosen_task,
                    input segment_selector, output ready);
endinterface

// ===== src/rrts_slot_mem.sv =====
// Task slot state table: one write port, one registered read port.
// Per-entry valid bits give the reset state (slot 0 running, rest unused).
// Depends on rrts_pkg.
module rrts_slot_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rrts_pkg::t_mem_ctl   i_ctl,
    input  logic [AW-1:0]        i_raddr,
    input  logic [AW-1:0]        i_waddr,
    input  rrts_pkg::t_slot      i_wdata,
    output rrts_pkg::t_slot      o_rdata
);
    import rrts_pkg::*;

    t_slot              r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    t_slot              r_rdata;

    // Valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // Storage and registered read; an unwritten entry reads as its reset state
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            if (r_vld[i_raddr]) begin
                r_rdata <= r_mem[i_raddr];
            end else if (i_raddr == '0) begin
                r_rdata <= SLOT_RUNNING;
            end else begin
                r_rdata <= SLOT_UNUSED;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rrts_list_mem.sv =====
// Run list memory: ordered running task numbers, one write and one
// registered read port. Entry 0 reads as task 0 until first written.
// Depends on rrts_pkg.
module rrts_list_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rrts_pkg::t_mem_ctl           i_ctl,
    input  logic [AW-1:0]                i_raddr,
    input  logic [AW-1:0]                i_waddr,
    input  logic [rrts_pkg::TASK_W-1:0]  i_wdata,
    output logic [rrts_pkg::TASK_W-1:0]  o_rdata
);
    import rrts_pkg::*;

    logic [TASK_W-1:0]  r_mem [DEPTH];
    logic               r_head_ok;
    logic [TASK_W-1:0]  r_rdata;

    // Head entry written flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_ok <= 1'b0;
        end else if (i_ctl.we && i_waddr == '0) begin
            r_head_ok <= 1'b1;
        end
    end

    // Storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            if (i_raddr == '0 && !r_head_ok) begin
                r_rdata <= '0;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rrts_seq.sv =====
// Scheduler sequencer: steps the slot table and run list one entry per cycle
// for allocate scans and sleep compaction, and holds the result register.
// Depends on rrts_pkg and the two memory modules.
module rrts_seq #(
    parameter int TASK_SLOTS = 32,
    parameter int IW         = 5,
    parameter int CW         = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rrts_pkg::BASE_W-1:0]   i_base,
    // command side
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  logic [rrts_pkg::CMD_W-1:0]    i_command,
    input  logic [rrts_pkg::TASK_W-1:0]   i_task_index,
    // result side
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [rrts_pkg::STAT_W-1:0]   o_status,
    output logic                          o_switched,
    output logic [rrts_pkg::TASK_W-1:0]   o_chosen_task,
    output logic [rrts_pkg::SEL_W-1:0]    o_segment_selector
);
    import rrts_pkg::*;

    localparam int XW = TASK_W + IW + 1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SRD   = 8'b0000_0010,
        S_SCHK  = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_SWEEP = 8'b0001_0000,
        S_FETCH = 8'b0010_0000,
        S_FDATA = 8'b0100_0000,
        S_RES   = 8'b1000_0000
    } t_state;

    // Registers
    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [TASK_W-1:0]  r_idx, n_idx;
    logic [CW-1:0]      r_rc, n_rc;
    logic [IW-1:0]      r_cp, n_cp;
    logic [CW-1:0]      r_ptr, n_ptr;
    logic               r_pend, n_pend;
    logic [IW-1:0]      r_chk, n_chk;
    logic               r_found, n_found;
    logic [IW-1:0]      r_fpos, n_fpos;
    t_status            r_res_status, n_res_status;
    logic               r_res_sw, n_res_sw;
    logic [TASK_W-1:0]  r_res_task, n_res_task;
    logic               r_res_fail, n_res_fail;
    logic               r_out_vld, n_out_vld;
    t_status            r_out_status, n_out_status;
    logic               r_out_sw, n_out_sw;
    logic [TASK_W-1:0]  r_out_task, n_out_task;
    logic [SEL_W-1:0]   r_out_sel, n_out_sel;

    // Memory ports
    t_mem_ctl           w_sctl, w_lctl;
    logic [IW-1:0]      w_sraddr, w_swaddr, w_lraddr, w_lwaddr;
    t_slot              w_swdata, w_sdat;
    logic [TASK_W-1:0]  w_lwdata, w_ldat;

    // Helpers
    logic [XW-1:0]      w_idx_x, w_chk_x;
    logic               w_idx_inr;
    logic [IW-1:0]      w_idx_a;
    logic [TASK_W-1:0]  w_chk_task;
    logic [CW-1:0]      w_cp_inc, w_rc_dec;
    logic               w_hit, w_last, w_eff_found;
    logic [IW-1:0]      w_eff_fpos;
    logic [BASE_W:0]    w_sum;
    logic [SEL_W-1:0]   w_sel;

    rrts_slot_mem #(.DEPTH(TASK_SLOTS), .AW(IW)) u_slot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sctl),
        .i_raddr (w_sraddr),
        .i_waddr (w_swaddr),
        .i_wdata (w_swdata),
        .o_rdata (w_sdat)
    );

    rrts_list_mem #(.DEPTH(TASK_SLOTS), .AW(IW)) u_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_lctl),
        .i_raddr (w_lraddr),
        .i_waddr (w_lwaddr),
        .i_wdata (w_lwdata),
        .o_rdata (w_ldat)
    );

    // Index range checks and width conversions
    assign w_idx_x    = XW'(r_idx);
    assign w_idx_inr  = w_idx_x < XW'(TASK_SLOTS);
    assign w_idx_a    = w_idx_x[IW-1:0];
    assign w_chk_x    = XW'(r_chk);
    assign w_chk_task = w_chk_x[TASK_W-1:0];
    assign w_cp_inc   = CW'(r_cp) + CW'(1);
    assign w_rc_dec   = r_rc - CW'(1);

    // Sweep compare on the word just read
    assign w_hit       = (w_ldat == r_idx);
    assign w_last      = (CW'(r_chk) == w_rc_dec);
    assign w_eff_found = r_found || w_hit;
    assign w_eff_fpos  = r_found ? r_fpos : r_chk;

    // Selector adder
    assign w_sum = {1'b0, i_base} + (BASE_W + 1)'(r_res_task);
    assign w_sel = {w_sum[SEL_W-SEL_SHIFT-1:0], {SEL_SHIFT{1'b0}}};

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_rc         = r_rc;
        n_cp         = r_cp;
        n_ptr        = r_ptr;
        n_pend       = r_pend;
        n_chk        = r_chk;
        n_found      = r_found;
        n_fpos       = r_fpos;
        n_res_status = r_res_status;
        n_res_sw     = r_res_sw;
        n_res_task   = r_res_task;
        n_res_fail   = r_res_fail;
        n_out_vld    = r_out_vld && !i_res_ready;
        n_out_status = r_out_status;
        n_out_sw     = r_out_sw;
        n_out_task   = r_out_task;
        n_out_sel    = r_out_sel;
        w_sctl       = '0;
        w_lctl       = '0;
        w_sraddr     = w_idx_a;
        w_swaddr     = w_idx_a;
        w_swdata     = SLOT_SLEEP;
        w_lraddr     = r_cp;
        w_lwaddr     = r_rc[IW-1:0];
        w_lwdata     = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd   = t_cmd'(i_command);
                    n_idx   = i_task_index;
                    n_ptr   = '0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    n_state = (t_cmd'(i_command) == CMD_ALLOC) ? S_SCAN : S_SRD;
                end
            end

            // read the named slot's state
            S_SRD: begin
                w_sctl.re = w_idx_inr;
                n_state   = S_SCHK;
            end

            S_SCHK: begin
                n_res_sw     = 1'b0;
                n_res_status = STAT_DONE;
                n_state      = S_FETCH;
                case (r_cmd)
                    CMD_RUN: begin
                        if (!w_idx_inr || w_sdat == SLOT_RUNNING ||
                            r_rc >= CW'(TASK_SLOTS)) begin
                            n_res_status = STAT_IGNORED;
                        end else begin
                            w_sctl.we = 1'b1;
                            w_swdata  = SLOT_RUNNING;
                            w_lctl.we = 1'b1;
                            n_rc      = r_rc + CW'(1);
                        end
                    end
                    CMD_TICK: begin
                        if (r_rc >= CW'(2)) begin
                            n_res_sw = 1'b1;
                            n_cp     = (w_cp_inc >= r_rc) ? '0 : w_cp_inc[IW-1:0];
                        end
                    end
                    CMD_SLEEP: begin
                        if (!w_idx_inr || w_sdat != SLOT_RUNNING || r_rc < CW'(2)) begin
                            n_res_status = STAT_IGNORED;
                        end else begin
                            n_state = S_SWEEP;
                        end
                    end
                    default: begin
                        n_res_status = STAT_IGNORED;
                    end
                endcase
            end

            // lowest unused slot; one slot read per cycle, checked in the next cycle
            S_SCAN: begin
                w_sraddr  = r_ptr[IW-1:0];
                w_sctl.re = r_ptr < CW'(TASK_SLOTS);
                n_pend    = w_sctl.re;
                n_chk     = r_ptr[IW-1:0];
                n_ptr     = r_ptr + CW'(1);
                if (r_pend) begin
                    if (w_sdat == SLOT_UNUSED) begin
                        w_sctl.we    = 1'b1;
                        w_swaddr     = r_chk;
                        w_swdata     = SLOT_SLEEP;
                        n_res_status = STAT_DONE;
                        n_res_sw     = 1'b0;
                        n_res_task   = w_chk_task;
                        n_res_fail   = 1'b0;
                        n_state      = S_RES;
                    end else if (CW'(r_chk) == CW'(TASK_SLOTS - 1)) begin
                        n_res_status = STAT_NO_SLOT;
                        n_res_sw     = 1'b0;
                        n_res_task   = '0;
                        n_res_fail   = 1'b1;
                        n_state      = S_RES;
                    end
                end
            end

            // find the task in the run list and shift later entries down by one
            S_SWEEP: begin
                w_lraddr  = r_ptr[IW-1:0];
                w_lctl.re = r_ptr < r_rc;
                n_pend    = w_lctl.re;
                n_chk     = r_ptr[IW-1:0];
                n_ptr     = r_ptr + CW'(1);
                if (r_pend) begin
                    if (!r_found && w_hit) begin
                        n_found = 1'b1;
                        n_fpos  = r_chk;
                    end
                    if (r_found) begin
                        w_lctl.we = 1'b1;
                        w_lwaddr  = r_chk - IW'(1);
                        w_lwdata  = w_ldat;
                    end
                    if (w_last) begin
                        n_state = S_FETCH;
                        if (w_eff_found) begin
                            n_res_status = STAT_DONE;
                            n_rc         = w_rc_dec;
                            w_sctl.we    = 1'b1;
                            w_swdata     = SLOT_SLEEP;
                            if (w_eff_fpos < r_cp) begin
                                n_cp = r_cp - IW'(1);
                            end else if (w_eff_fpos == r_cp) begin
                                // current task went to sleep: switch
                                n_res_sw = 1'b1;
                                if (CW'(r_cp) >= w_rc_dec) begin
                                    n_cp = '0;
                                end
                            end
                        end else begin
                            n_res_status = STAT_IGNORED;
                        end
                    end
                end
            end

            // read the task at the current position
            S_FETCH: begin
                w_lctl.re = 1'b1;
                n_state   = S_FDATA;
            end

            S_FDATA: begin
                n_res_task = w_ldat;
                n_res_fail = 1'b0;
                n_state    = S_RES;
            end

            // load the output register once it is free
            S_RES: begin
                if (!r_out_vld || i_res_ready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_sw     = r_res_sw;
                    n_out_task   = r_res_task;
                    n_out_sel    = r_res_fail ? '0 : w_sel;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rc      <= CW'(1);
            r_cp      <= '0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rc      <= n_rc;
            r_cp      <= n_cp;
            r_pend    <= n_pend;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_idx        <= n_idx;
        r_ptr        <= n_ptr;
        r_chk        <= n_chk;
        r_fpos       <= n_fpos;
        r_res_status <= n_res_status;
        r_res_sw     <= n_res_sw;
        r_res_task   <= n_res_task;
        r_res_fail   <= n_res_fail;
        r_out_status <= n_out_status;
        r_out_sw     <= n_out_sw;
        r_out_task   <= n_out_task;
        r_out_sel    <= n_out_sel;
    end

    assign o_cmd_ready        = (r_state == S_IDLE);
    assign o_res_valid        = r_out_vld;
    assign o_status           = r_out_status;
    assign o_switched         = r_out_sw;
    assign o_chosen_task      = r_out_task;
    assign o_segment_selector = r_out_sel;

endmodule

// ===== src/round_robin_task_scheduler.sv =====
// Round-robin task scheduler. One command word at a time; ready is low while busy.
// Allocate scans the slot table one slot per cycle; sleep sweeps the run list one entry
// per cycle; run, tick and refused run or sleep commands take neither pass.
// The next word is accepted in the cycle after the result register is loaded.
// Synchronous active-low reset; the slot table reset state is immediate (no clearing pass).
module round_robin_task_scheduler #(
    parameter int TASK_SLOTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rrts_pkg::BASE_W-1:0]   i_cfg_wdata,
    rrts_cmd_if.sink                      i_cmd,
    rrts_res_if.source                    o_res
);
    import rrts_pkg::*;

    localparam int IW = $clog2(TASK_SLOTS);
    localparam int CW = $clog2(TASK_SLOTS + 1);

    logic [BASE_W-1:0] r_descriptor_base;

    // Descriptor base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_descriptor_base <= BASE_RESET;
        end else if (i_cfg_we) begin
            r_descriptor_base <= i_cfg_wdata;
        end
    end

    rrts_seq #(.TASK_SLOTS(TASK_SLOTS), .IW(IW), .CW(CW)) u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_base             (r_descriptor_base),
        .i_cmd_valid        (i_cmd.valid),
        .o_cmd_ready        (i_cmd.ready),
        .i_command          (i_cmd.command),
        .i_task_index       (i_cmd.task_index),
        .o_res_valid        (o_res.valid),
        .i_res_ready        (o_res.ready),
        .o_status           (o_res.status),
        .o_switched         (o_res.switched),
        .o_chosen_task      (o_res.chosen_task),
        .o_segment_selector (o_res.segment_selector)
    );

endmodule

// ===== src/rrts_checker.sv =====
// Port-level checks of the task scheduler, bound to the top level.
// Depends on rrts_pkg and round_robin_task_scheduler.
module rrts_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [rrts_pkg::STAT_W-1:0]   i_status,
    input  logic                          i_switched,
    input  logic [rrts_pkg::TASK_W-1:0]   i_chosen_task,
    input  logic [rrts_pkg::SEL_W-1:0]    i_segment_selector
);
    import rrts_pkg::*;

    // a result word stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped before taken");

    // one command at a time: busy right after an accepted word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while busy");

    // failed allocate reports task 0 with a zero selector
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == STAT_NO_SLOT |->
            i_chosen_task == '0 && i_segment_selector == '0 && !i_switched)
        else $error("failed allocate carries a task");

    // a switch only comes with a completed command
    a_switch_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_switched |-> i_status == STAT_DONE)
        else $error("switch flagged on a refused command");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_cmd.valid),
    .i_in_ready         (i_cmd.ready),
    .i_out_valid        (o_res.valid),
    .i_out_ready        (o_res.ready),
    .i_status           (o_res.status),
    .i_switched         (o_res.switched),
    .i_chosen_task      (o_res.chosen_task),
    .i_segment_selector (o_res.segment_selector)
);

// ===== bench/rrts_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the round-robin task scheduler. It mirrors the task table and
// run list, predicts each result word, and compares it with what the block returns.
// Depends on rrts_pkg and on the rrts_cmd_if and rrts_res_if channel interfaces.
module rrts_result_checker #(
    parameter int TASK_SLOTS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rrts_pkg::BASE_W-1:0]  i_cfg_wdata,
    rrts_cmd_if                          i_cmd,
    rrts_res_if                          i_res,
    output int                           o_err_count,
    output int                           o_pending
);
    import rrts_pkg::*;

    typedef struct packed {
        t_status           status;
        logic              switched;
        logic [TASK_W-1:0] chosen;
        logic [SEL_W-1:0]  selector;
    } t_sched_result;

    // Mirror of the scheduler state
    t_slot             slot_table [TASK_SLOTS];
    logic [TASK_W-1:0] run_order  [TASK_SLOTS];
    int                run_count;
    int                position;
    logic [BASE_W-1:0] seg_base;

    t_sched_result expected_results [$];
    int            err_total = 0;

    // Task owning the processor; zero if the position is out of the list
    function automatic logic [TASK_W-1:0] current_task();
        if (position < run_count) begin
            return run_order[position];
        end
        return '0;
    endfunction

    function automatic t_sched_result make_result(t_status st, logic sw,
                                                  logic [TASK_W-1:0] tk);
        t_sched_result r;
        logic [31:0]   sum;
        sum        = 32'(seg_base) + 32'(tk);
        r.status   = st;
        r.switched = sw;
        r.chosen   = tk;
        r.selector = SEL_W'(sum << SEL_SHIFT);
        return r;
    endfunction

    // Apply one command word to the mirror and produce the expected result word
    task automatic predict_word(input t_cmd cmd, input logic [TASK_W-1:0] ix,
                                output t_sched_result w);
        int   k;
        int   pos;
        logic found;
        logic was_current;
        case (cmd)
            CMD_ALLOC: begin
                found = 1'b0;
                for (k = 0; k < TASK_SLOTS; k++) begin
                    if (!found && slot_table[k] == SLOT_UNUSED) begin
                        slot_table[k] = SLOT_SLEEP;
                        w     = make_result(STAT_DONE, 1'b0, TASK_W'(k));
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    w          = make_result(STAT_NO_SLOT, 1'b0, '0);
                    w.selector = '0;
                end
            end
            CMD_RUN: begin
                if (int'(ix) >= TASK_SLOTS || slot_table[ix] == SLOT_RUNNING ||
                    run_count >= TASK_SLOTS) begin
                    w = make_result(STAT_IGNORED, 1'b0, current_task());
                end else begin
                    // unused and sleeping slots both join the end of the list
                    slot_table[ix]       = SLOT_RUNNING;
                    run_order[run_count] = ix;
                    run_count++;
                    w = make_result(STAT_DONE, 1'b0, current_task());
                end
            end
            CMD_TICK: begin
                if (run_count >= 2) begin
                    position++;
                    if (position >= run_count) begin
                        position = 0;
                    end
                    w = make_result(STAT_DONE, 1'b1, current_task());
                end else begin
                    w = make_result(STAT_DONE, 1'b0, current_task());
                end
            end
            default: begin
                // sleep: refused for non-running tasks and for the last runner
                if (int'(ix) >= TASK_SLOTS || slot_table[ix] != SLOT_RUNNING ||
                    run_count < 2) begin
                    w = make_result(STAT_IGNORED, 1'b0, current_task());
                end else begin
                    was_current = (current_task() == ix);
                    pos = 0;
                    while (pos < run_count && run_order[pos] != ix) begin
                        pos++;
                    end
                    run_count--;
                    if (pos < position) begin
                        position--;
                    end
                    for (k = pos; k < run_count; k++) begin
                        run_order[k] = run_order[k + 1];
                    end
                    slot_table[ix] = SLOT_SLEEP;
                    if (was_current) begin
                        if (position >= run_count) begin
                            position = 0;
                        end
                        w = make_result(STAT_DONE, 1'b1, current_task());
                    end else begin
                        w = make_result(STAT_DONE, 1'b0, current_task());
                    end
                end
            end
        endcase
    endtask

    // Watch both channels and the config port at each rising edge
    always @(posedge i_clk) begin : watch
        t_sched_result want;
        t_sched_result got;
        int            k;
        if (!i_rst_n) begin
            for (k = 0; k < TASK_SLOTS; k++) begin
                slot_table[k] = SLOT_UNUSED;
                run_order[k]  = '0;
            end
            slot_table[0] = SLOT_RUNNING;
            run_count     = 1;
            position      = 0;
            seg_base      = BASE_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                seg_base = i_cfg_wdata;
            end
            if (i_res.valid && i_res.ready) begin
                got.status   = t_status'(i_res.status);
                got.switched = i_res.switched;
                got.chosen   = i_res.chosen_task;
                got.selector = i_res.segment_selector;
                if (expected_results.size() == 0) begin
                    err_total++;
                    if (err_total <= 10) begin
                        $display("%0t: extra result: status %0d sw %0d task %0d sel %h",
                                 $realtime, got.status, got.switched, got.chosen,
                                 got.selector);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        err_total++;
                        if (err_total <= 10) begin
                            $display("%0t: expected status %0d sw %0d task %0d sel %h",
                                     $realtime, want.status, want.switched, want.chosen,
                                     want.selector);
                            $display("%0t: actual   status %0d sw %0d task %0d sel %h",
                                     $realtime, got.status, got.switched, got.chosen,
                                     got.selector);
                        end
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                predict_word(t_cmd'(i_cmd.command), i_cmd.task_index, want);
                expected_results.push_back(want);
            end
        end
        o_pending   <= expected_results.size();
        o_err_count <= err_total;
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Top of the task scheduler bench: clock, reset, command and config stimulus,
// result back-pressure and the verdict. Depends on rrts_pkg, the channel
// interfaces, round_robin_task_scheduler and rrts_result_checker.
module testbench;
    import rrts_pkg::*;

    localparam int TASK_SLOTS    = 32;
    localparam int DRAIN_CYCLES  = TASK_SLOTS + 32;
    localparam int HOLD_START    = 3000;
    localparam int HOLD_CYCLES   = 500;
    localparam int CALM_RX_FIRST = 8000;
    localparam int CALM_RX_LAST  = 12000;
    localparam int CALM_TX_FIRST = 600;
    localparam int CALM_TX_LAST  = 800;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_WORDS   = 320;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [BASE_W-1:0] i_cfg_wdata;
    int                err_count;
    int                pending;
    int                words_sent;

    rrts_cmd_if cmd_bus ();
    rrts_res_if res_bus ();

    round_robin_task_scheduler #(
        .TASK_SLOTS (TASK_SLOTS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_bus),
        .o_res       (res_bus)
    );

    rrts_result_checker #(
        .TASK_SLOTS (TASK_SLOTS)
    ) result_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_bus),
        .i_res       (res_bus),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Offer one command word, with an occasional gap first; returns at a falling edge
    task automatic send_word(input t_cmd cmd, input logic [TASK_W-1:0] idx);
        int gap;
        if (!(words_sent >= CALM_TX_FIRST && words_sent < CALM_TX_LAST) &&
            $urandom_range(99) < 15) begin
            gap = $urandom_range(4, 1);
            cmd_bus.valid      <= 1'b0;
            cmd_bus.command    <= CMD_W'($urandom);
            cmd_bus.task_index <= TASK_W'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.command    <= cmd;
        cmd_bus.task_index <= idx;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every expected result word has come back
    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_base(input logic [BASE_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Result side: random back-pressure, one long hold-off, one calm stretch
    initial begin : result_sink
        int cycle;
        cycle = 0;
        res_bus.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            cycle++;
            if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES) begin
                res_bus.ready <= 1'b0;
            end else if (cycle >= CALM_RX_FIRST && cycle < CALM_RX_LAST) begin
                res_bus.ready <= 1'b1;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= 15);
            end
        end
    end

    // Command stimulus and verdict
    initial begin : stimulus
        int                r;
        int                phase;
        int                n;
        logic [BASE_W-1:0] base_val;
        words_sent          = 0;
        cmd_bus.valid      <= 1'b0;
        cmd_bus.command    <= CMD_ALLOC;
        cmd_bus.task_index <= '0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= '0;
        i_rst_n            <= 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, descriptor base at its reset value
        send_word(CMD_TICK,  5'd0);   // single runner: no switch
        send_word(CMD_SLEEP, 5'd0);   // last runner cannot sleep
        send_word(CMD_SLEEP, 5'd7);   // unused slot is not running
        send_word(CMD_ALLOC, 5'd0);
        send_word(CMD_ALLOC, 5'd31);
        send_word(CMD_RUN,   5'd1);
        send_word(CMD_RUN,   5'd1);   // already running
        send_word(CMD_RUN,   5'd31);  // unused slot runs directly
        send_word(CMD_RUN,   5'd2);
        send_word(CMD_TICK,  5'd0);
        send_word(CMD_TICK,  5'd0);
        send_word(CMD_SLEEP, 5'd0);   // ahead of the position: position moves back
        send_word(CMD_SLEEP, 5'd31);  // current task sleeps: switch
        send_word(CMD_SLEEP, 5'd2);   // current at list end: wraps to the front
        send_word(CMD_SLEEP, 5'd2);   // now sleeping
        send_word(CMD_RUN,   5'd2);
        send_word(CMD_RUN,   5'd0);
        send_word(CMD_TICK,  5'd0);
        send_word(CMD_TICK,  5'd0);
        send_word(CMD_TICK,  5'd0);   // wraps round
        send_word(CMD_ALLOC, 5'd0);
        send_word(CMD_SLEEP, 5'd31);

        // Random phases, each under a new descriptor base
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            case (phase)
                0:       base_val = '1;
                1:       base_val = '0;
                default: base_val = BASE_W'($urandom);
            endcase
            write_base(base_val);
            for (n = 0; n < PHASE_WORDS; n++) begin
                r = $urandom_range(99);
                if (r < 15) begin
                    send_word(CMD_ALLOC, TASK_W'($urandom));
                end else if (r < 50) begin
                    send_word(CMD_RUN, TASK_W'($urandom_range(TASK_SLOTS - 1)));
                end else if (r < 75) begin
                    send_word(CMD_TICK, TASK_W'($urandom));
                end else begin
                    send_word(CMD_SLEEP, TASK_W'($urandom_range(TASK_SLOTS - 1)));
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== round_robin_task_scheduler.f =====
src/rrts_pkg.sv
src/rrts_cmd_if.sv
src/rrts_res_if.sv
src/rrts_slot_mem.sv
src/rrts_list_mem.sv
src/rrts_seq.sv
src/round_robin_task_scheduler.sv
src/rrts_checker.sv
bench/rrts_result_checker.sv
bench/testbench.sv
